>>> rtl/bfg_pkg.sv
package bfg_pkg;

  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned SAMPLE_COUNT = 8;
  localparam int unsigned MID_LO       = SAMPLE_COUNT / 4;
  localparam int unsigned MID_COUNT    = SAMPLE_COUNT / 2;
  localparam int unsigned RANK_W       = $clog2(SAMPLE_COUNT);
  localparam int unsigned ADC_BITS_DEF = 12;

  localparam int unsigned MV_W   = 13;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned REF_W  = 12;
  localparam int unsigned DIV_W  = 7;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_REFERENCE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIVIDER   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FULL      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EMPTY     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW       = 3'd4;

  localparam logic [REF_W-1:0] REFERENCE_RST = 12'd3300;
  localparam logic [DIV_W-1:0] DIVIDER_RST   = 7'd20;
  localparam logic [MV_W-1:0]  FULL_RST      = 13'd4200;
  localparam logic [MV_W-1:0]  EMPTY_RST     = 13'd3000;
  localparam logic [PCT_W-1:0] LOW_RST       = 7'd20;

  localparam logic [STAT_W-1:0] STAT_DISCHARGING = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CHARGING    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL        = 2'd2;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // divide by ten: multiply by ceil(2^35 / 10), keep bits from 35 up
  localparam int unsigned   DIV10_W     = 32;
  localparam int unsigned   DIV10_SHIFT = 35;
  localparam logic [DIV10_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;

  localparam int unsigned OCV_POINTS = 11;
  localparam int unsigned SEG_W      = $clog2(OCV_POINTS - 1);

  localparam logic [MV_W-1:0] OCV_MV [OCV_POINTS] = '{
    13'd4200, 13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820,
    13'd3790, 13'd3770, 13'd3730, 13'd3690, 13'd3000
  };

  localparam logic [PCT_W-1:0] OCV_PCT [OCV_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd10, 7'd0
  };

  // reciprocal of each segment span, ceil(2^RECIP_K / span)
  localparam int unsigned RECIP_K = 24;
  localparam int unsigned RECIP_W = 20;
  localparam logic [RECIP_W-1:0] OCV_RECIP [OCV_POINTS-1] = '{
    RECIP_W'(((1 << RECIP_K) + 140 - 1) / 140),
    RECIP_W'(((1 << RECIP_K) + 80 - 1) / 80),
    RECIP_W'(((1 << RECIP_K) + 60 - 1) / 60),
    RECIP_W'(((1 << RECIP_K) + 50 - 1) / 50),
    RECIP_W'(((1 << RECIP_K) + 50 - 1) / 50),
    RECIP_W'(((1 << RECIP_K) + 30 - 1) / 30),
    RECIP_W'(((1 << RECIP_K) + 20 - 1) / 20),
    RECIP_W'(((1 << RECIP_K) + 40 - 1) / 40),
    RECIP_W'(((1 << RECIP_K) + 40 - 1) / 40),
    RECIP_W'(((1 << RECIP_K) + 690 - 1) / 690)
  };

  typedef logic [SAMPLE_W-1:0] bfg_sample_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic                charging;
    logic                standby;
  } bfg_in_t;

  typedef struct packed {
    logic [MV_W-1:0]   batt_mv;
    logic [PCT_W-1:0]  percent;
    logic [STAT_W-1:0] status;
    logic              low_battery;
  } bfg_out_t;

  typedef struct packed {
    logic lane;
    logic merge;
    logic seg;
    logic est;
  } bfg_step_t;

endpackage

>>> rtl/bfg_lane.sv
module bfg_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic                clk,
  input  bfg_pkg::bfg_step_t  step,
  input  bfg_pkg::bfg_sample_t smp [bfg_pkg::SAMPLE_COUNT],
  output bfg_pkg::bfg_sample_t pick_r
);

  logic [bfg_pkg::RANK_W-1:0] rank;
  logic                       keep;
  bfg_pkg::bfg_sample_t       pick_nxt;

  // stable rank: smaller values first, equal values by lane order
  always_comb begin
    rank = '0;
    for (int j = 0; j < bfg_pkg::SAMPLE_COUNT; j++) begin
      if (j != LANE) begin
        if ((smp[j] < smp[LANE]) || ((j < LANE) && (smp[j] == smp[LANE]))) begin
          rank = rank + 1'b1;
        end
      end
    end
  end

  assign keep = (rank >= bfg_pkg::RANK_W'(bfg_pkg::MID_LO)) &&
                (rank < bfg_pkg::RANK_W'(bfg_pkg::MID_LO + bfg_pkg::MID_COUNT));
  assign pick_nxt = keep ? smp[LANE] : '0;

  always_ff @(posedge clk) begin
    if (step.lane) begin
      pick_r <= pick_nxt;
    end
  end

endmodule

>>> rtl/bfg_merge.sv
module bfg_merge (
  input  logic                 clk,
  input  bfg_pkg::bfg_step_t   step,
  input  bfg_pkg::bfg_sample_t pick [bfg_pkg::SAMPLE_COUNT],
  output bfg_pkg::bfg_sample_t avg_r
);

  localparam int unsigned SUM_W = bfg_pkg::SAMPLE_W + $clog2(bfg_pkg::SAMPLE_COUNT);
  localparam int unsigned AVG_SHIFT = $clog2(bfg_pkg::MID_COUNT);

  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_shr;
  bfg_pkg::bfg_sample_t avg_nxt;

  always_comb begin
    sum = '0;
    for (int i = 0; i < bfg_pkg::SAMPLE_COUNT; i++) begin
      sum = sum + SUM_W'(pick[i]);
    end
  end

  assign sum_shr = sum >> AVG_SHIFT;
  assign avg_nxt = sum_shr[bfg_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (step.merge) begin
      avg_r <= avg_nxt;
    end
  end

endmodule

>>> rtl/bfg_ocv.sv
module bfg_ocv (
  input  logic                       clk,
  input  bfg_pkg::bfg_step_t         step,
  input  logic [bfg_pkg::MV_W-1:0]   mv,
  output logic [bfg_pkg::PCT_W-1:0]  est_r
);

  localparam int unsigned N_W   = bfg_pkg::MV_W + bfg_pkg::PCT_W;
  localparam int unsigned FR_W  = N_W + bfg_pkg::RECIP_W;
  localparam int unsigned LAST  = bfg_pkg::OCV_POINTS - 1;

  logic [bfg_pkg::SEG_W-1:0]  seg_nxt, seg_r;
  logic                       top_nxt, top_r;
  logic                       bot_nxt, bot_r;
  logic [bfg_pkg::MV_W-1:0]   diff;
  logic [bfg_pkg::PCT_W-1:0]  dp;
  logic [N_W-1:0]             n_nxt, n_r;
  logic [FR_W-1:0]            frac_prod;
  logic [bfg_pkg::PCT_W-1:0]  frac;
  logic [bfg_pkg::PCT_W-1:0]  est_nxt;

  assign top_nxt = mv >= bfg_pkg::OCV_MV[0];
  assign bot_nxt = mv <= bfg_pkg::OCV_MV[LAST];

  // first segment whose lower point is at or below mv
  always_comb begin
    seg_nxt = bfg_pkg::SEG_W'(LAST - 1);
    for (int i = LAST - 1; i >= 0; i--) begin
      if (mv >= bfg_pkg::OCV_MV[i+1]) begin
        seg_nxt = bfg_pkg::SEG_W'(i);
      end
    end
  end

  assign diff  = mv - bfg_pkg::OCV_MV[seg_nxt + 1'b1];
  assign dp    = bfg_pkg::OCV_PCT[seg_nxt] - bfg_pkg::OCV_PCT[seg_nxt + 1'b1];
  assign n_nxt = N_W'(diff) * N_W'(dp);

  always_ff @(posedge clk) begin
    if (step.seg) begin
      seg_r <= seg_nxt;
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      n_r   <= n_nxt;
    end
  end

  assign frac_prod = FR_W'(n_r) * FR_W'(bfg_pkg::OCV_RECIP[seg_r]);
  assign frac      = frac_prod[bfg_pkg::RECIP_K +: bfg_pkg::PCT_W];

  always_comb begin
    if (top_r) begin
      est_nxt = bfg_pkg::PCT_MAX;
    end else if (bot_r) begin
      est_nxt = '0;
    end else begin
      est_nxt = bfg_pkg::OCV_PCT[seg_r + 1'b1] + frac;
    end
  end

  always_ff @(posedge clk) begin
    if (step.est) begin
      est_r <= est_nxt;
    end
  end

endmodule

>>> rtl/battery_fuel_gauge_core.sv
// Voltage-based fuel gauge for one Li-ion cell. Each request carries eight raw
// ADC samples and the charger flags and yields one result: clamped voltage in
// mV, state of charge in percent, charger status and the low-battery flag.
// One request is worked on at a time; a new one is taken only after the
// previous one has left the held-percent update, which waits while the
// output register still holds an unread result, and the next request may
// be accepted while a result still waits there. The sequencer steps the
// eight rank lanes, the merge adder, the two scaling multiplies, the
// reciprocal divide by ten, the clamp, the two stages of table
// interpolation and the held-percent update. The registers sit on a
// zero-wait APB port at byte address 4*index: reference mV, divider ratio
// times ten, full mV, empty mV, low percent.
module battery_fuel_gauge_core #(
  parameter int unsigned ADC_BITS = bfg_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bfg_pkg::bfg_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bfg_pkg::bfg_out_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfg_pkg::PADDR_W-1:0]       paddr,
  input  logic [bfg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bfg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned SW       = bfg_pkg::SAMPLE_W;
  localparam int unsigned PROD1_W  = SW + bfg_pkg::REF_W;
  localparam int unsigned VADC_W   = PROD1_W - ADC_BITS;
  localparam int unsigned SCALED_W = VADC_W + bfg_pkg::DIV_W;
  localparam int unsigned QPROD_W  = SCALED_W + bfg_pkg::DIV10_W;
  localparam int unsigned Q_W      = QPROD_W - bfg_pkg::DIV10_SHIFT;
  localparam int unsigned CMP_W    = (Q_W > bfg_pkg::MV_W) ? Q_W : bfg_pkg::MV_W;
  localparam int unsigned BLEND_W  = bfg_pkg::PCT_W + 2;
  localparam logic [SW-1:0] SAMPLE_MASK =
    (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_RANK  = 10'b00_0000_0010,
    S_SUM   = 10'b00_0000_0100,
    S_MUL1  = 10'b00_0000_1000,
    S_MUL2  = 10'b00_0001_0000,
    S_DIV   = 10'b00_0010_0000,
    S_CLAMP = 10'b00_0100_0000,
    S_SEG   = 10'b00_1000_0000,
    S_RCP   = 10'b01_0000_0000,
    S_UPD   = 10'b10_0000_0000
  } fsm_state_t;

  fsm_state_t                    state_r, state_nxt;
  bfg_pkg::bfg_in_t              in_r;
  bfg_pkg::bfg_sample_t          smp  [bfg_pkg::SAMPLE_COUNT];
  bfg_pkg::bfg_sample_t          pick [bfg_pkg::SAMPLE_COUNT];
  bfg_pkg::bfg_sample_t          avg;
  bfg_pkg::bfg_step_t            step;
  logic [PROD1_W-1:0]            prod1_r;
  logic [VADC_W-1:0]             vadc;
  logic [SCALED_W-1:0]           scaled_r;
  logic [QPROD_W-1:0]            qprod_r;
  logic [Q_W-1:0]                q;
  logic [CMP_W-1:0]              q_ext;
  logic [bfg_pkg::MV_W-1:0]      mv_hi;
  logic [bfg_pkg::MV_W-1:0]      mv_nxt, mv_r;
  logic [bfg_pkg::PCT_W-1:0]     est;

  logic [bfg_pkg::REF_W-1:0]     ref_r;
  logic [bfg_pkg::DIV_W-1:0]     div_r;
  logic [bfg_pkg::MV_W-1:0]      full_r;
  logic [bfg_pkg::MV_W-1:0]      empty_r;
  logic [bfg_pkg::PCT_W-1:0]     lowp_r;
  logic [bfg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  logic [bfg_pkg::PCT_W-1:0]     held_pct_r, held_pct_nxt;
  logic                          seen_r;
  logic [BLEND_W-1:0]            blend_sum;
  logic [bfg_pkg::PCT_W-1:0]     blend;
  logic [bfg_pkg::STAT_W-1:0]    status_nxt;
  logic                          upd_go;
  logic                          out_valid_r;
  bfg_pkg::bfg_out_t             out_data_r, out_data_nxt;

  // request intake and sequencer
  assign in_ready = (state_r == S_IDLE);
  assign upd_go   = !out_valid_r || out_ready;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = in_valid ? S_RANK : S_IDLE;
      S_RANK:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_DIV;
      S_DIV:   state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_SEG;
      S_SEG:   state_nxt = S_RCP;
      S_RCP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = upd_go ? S_IDLE : S_UPD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    smp[0] = in_r.sample_0 & SAMPLE_MASK;
    smp[1] = in_r.sample_1 & SAMPLE_MASK;
    smp[2] = in_r.sample_2 & SAMPLE_MASK;
    smp[3] = in_r.sample_3 & SAMPLE_MASK;
    smp[4] = in_r.sample_4 & SAMPLE_MASK;
    smp[5] = in_r.sample_5 & SAMPLE_MASK;
    smp[6] = in_r.sample_6 & SAMPLE_MASK;
    smp[7] = in_r.sample_7 & SAMPLE_MASK;
  end

  assign step.lane  = (state_r == S_RANK);
  assign step.merge = (state_r == S_SUM);
  assign step.seg   = (state_r == S_SEG);
  assign step.est   = (state_r == S_RCP);

  // rank lanes and middle-four merge
  for (genvar g = 0; g < bfg_pkg::SAMPLE_COUNT; g++) begin : g_lane
    bfg_lane #(
      .LANE (g)
    ) u_lane (
      .clk    (clk),
      .step   (step),
      .smp    (smp),
      .pick_r (pick[g])
    );
  end

  bfg_merge u_merge (
    .clk   (clk),
    .step  (step),
    .pick  (pick),
    .avg_r (avg)
  );

  // scaling to millivolts
  assign vadc = prod1_r[ADC_BITS +: VADC_W];
  assign q    = qprod_r[bfg_pkg::DIV10_SHIFT +: Q_W];

  always_ff @(posedge clk) begin
    if (state_r == S_MUL1) begin
      prod1_r <= PROD1_W'(avg) * PROD1_W'(ref_r);
    end
    if (state_r == S_MUL2) begin
      scaled_r <= SCALED_W'(vadc) * SCALED_W'(div_r);
    end
    if (state_r == S_DIV) begin
      qprod_r <= QPROD_W'(scaled_r) * QPROD_W'(bfg_pkg::DIV10_RECIP);
    end
    if (state_r == S_CLAMP) begin
      mv_r <= mv_nxt;
    end
  end

  // upper clamp first, lower clamp last
  assign q_ext  = CMP_W'(q);
  assign mv_hi  = (q_ext > CMP_W'(full_r)) ? full_r : q_ext[bfg_pkg::MV_W-1:0];
  assign mv_nxt = (mv_hi < empty_r) ? empty_r : mv_hi;

  bfg_ocv u_ocv (
    .clk   (clk),
    .step  (step),
    .mv    (mv_r),
    .est_r (est)
  );

  // held percent update
  assign blend_sum = (BLEND_W'(held_pct_r) << 1) + BLEND_W'(held_pct_r) + BLEND_W'(est);
  assign blend     = blend_sum[BLEND_W-1:2];

  always_comb begin
    if (in_r.standby) begin
      status_nxt   = bfg_pkg::STAT_FULL;
      held_pct_nxt = bfg_pkg::PCT_MAX;
    end else if (in_r.charging) begin
      status_nxt   = bfg_pkg::STAT_CHARGING;
      held_pct_nxt = (est > held_pct_r) ? est : held_pct_r;
    end else begin
      status_nxt = bfg_pkg::STAT_DISCHARGING;
      if (!seen_r) begin
        held_pct_nxt = est;
      end else begin
        held_pct_nxt = (blend < held_pct_r) ? blend : held_pct_r;
      end
    end
  end

  always_comb begin
    out_data_nxt.batt_mv     = mv_r;
    out_data_nxt.percent     = held_pct_nxt;
    out_data_nxt.status      = status_nxt;
    out_data_nxt.low_battery = (held_pct_nxt <= lowp_r) &&
                               (status_nxt == bfg_pkg::STAT_DISCHARGING);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_pct_r  <= bfg_pkg::PCT_MAX;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if ((state_r == S_UPD) && upd_go) begin
      held_pct_r  <= held_pct_nxt;
      seen_r      <= 1'b1;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_UPD) && upd_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[bfg_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= bfg_pkg::REFERENCE_RST;
      div_r   <= bfg_pkg::DIVIDER_RST;
      full_r  <= bfg_pkg::FULL_RST;
      empty_r <= bfg_pkg::EMPTY_RST;
      lowp_r  <= bfg_pkg::LOW_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bfg_pkg::REG_REFERENCE: ref_r   <= pwdata[bfg_pkg::REF_W-1:0];
        bfg_pkg::REG_DIVIDER:   div_r   <= pwdata[bfg_pkg::DIV_W-1:0];
        bfg_pkg::REG_FULL:      full_r  <= pwdata[bfg_pkg::MV_W-1:0];
        bfg_pkg::REG_EMPTY:     empty_r <= pwdata[bfg_pkg::MV_W-1:0];
        bfg_pkg::REG_LOW:       lowp_r  <= pwdata[bfg_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bfg_pkg::REG_REFERENCE: prdata = bfg_pkg::CFG_DATA_W'(ref_r);
      bfg_pkg::REG_DIVIDER:   prdata = bfg_pkg::CFG_DATA_W'(div_r);
      bfg_pkg::REG_FULL:      prdata = bfg_pkg::CFG_DATA_W'(full_r);
      bfg_pkg::REG_EMPTY:     prdata = bfg_pkg::CFG_DATA_W'(empty_r);
      bfg_pkg::REG_LOW:       prdata = bfg_pkg::CFG_DATA_W'(lowp_r);
      default:                prdata = '0;
    endcase
  end

endmodule

>>> rtl/bfg_checker.sv
module bfg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bfg_pkg::bfg_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.percent <= bfg_pkg::PCT_MAX)
    else $error("percent above full scale");

  a_full_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == bfg_pkg::STAT_FULL) |->
      out_data.percent == bfg_pkg::PCT_MAX)
    else $error("full status without full percent");

  a_low_dis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.low_battery |->
      out_data.status == bfg_pkg::STAT_DISCHARGING)
    else $error("low flag outside discharge");

endmodule

bind battery_fuel_gauge_core bfg_checker u_bfg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
